@@ rtl/core/tcs_pkg.sv @@
package tcs_pkg;

    // Geometry
    localparam int RING_LINES   = 256;
    localparam int VIEW_ROWS    = 24;
    localparam int LINE_COLS    = 80;
    localparam int BAR_CELLS    = 45;
    localparam int RING_BYTES   = RING_LINES * LINE_COLS;
    localparam int VIEW_MAX_LIM = RING_LINES - VIEW_ROWS;

    // Widths
    localparam int LINE_W = $clog2(RING_LINES);
    localparam int ADDR_W = $clog2(RING_BYTES);
    localparam int COL_W  = 7;
    localparam int IN_W   = 32;
    localparam int OUT_W  = 40;

    // Operations
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_KEY   = 2'd1,
        OP_READ  = 2'd2,
        OP_BAR   = 2'd3
    } op_t;

    // Scancodes
    localparam logic [8:0] SC_UP        = 9'h148;
    localparam logic [8:0] SC_DOWN      = 9'h150;
    localparam logic [8:0] SC_PAGE_UP   = 9'h149;
    localparam logic [8:0] SC_PAGE_DOWN = 9'h151;
    localparam logic [8:0] SC_ESC       = 9'h001;

    // Characters and glyphs
    localparam logic [7:0] CH_NEWLINE  = 8'd10;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_PRINT_LO = 8'd32;
    localparam logic [7:0] CH_PRINT_HI = 8'd127;
    localparam logic [7:0] GLYPH_BOTH  = 8'hdb;
    localparam logic [7:0] GLYPH_LEFT  = 8'hdd;
    localparam logic [7:0] GLYPH_RIGHT = 8'hde;
    localparam logic [7:0] GLYPH_NONE  = 8'h20;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic blank_start;
        logic blank_sel_cur;
        logic blank_step;
        logic write_char;
        logic new_line;
        logic key_apply;
        logic read_req;
        logic read_cap;
        logic bar_mul;
        logic bar_cap;
        logic out_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic is_newline;
        logic is_print;
        logic cur_valid;
        logic blank_last;
        logic col_wrap;
        logic out_free;
    } dp_sts_t;

endpackage

@@ rtl/core/tcs_ram.sv @@
module tcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/tcs_ctrl.sv @@
module tcs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tcs_pkg::dp_sts_t sts,
    output tcs_pkg::dp_cmd_t cmd
);
    import tcs_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DECODE = 11'b00000000010,
        S_BLANK  = 11'b00000000100,
        S_WRITE  = 11'b00000001000,
        S_NEWLN  = 11'b00000010000,
        S_KEY    = 11'b00000100000,
        S_RDREQ  = 11'b00001000000,
        S_RDWAIT = 11'b00010000000,
        S_BARMUL = 11'b00100000000,
        S_BARCMP = 11'b01000000000,
        S_FINISH = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   after_write_reg, after_write_next;

    assign in_ready = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        after_write_next = after_write_reg;
        cmd              = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.op)
                    OP_WRITE:
                    begin
                        if (sts.is_newline)
                        begin
                            cmd.blank_start  = 1'b1;
                            after_write_next = 1'b0;
                            state_next       = S_BLANK;
                        end
                        else if (sts.is_print)
                        begin
                            if (sts.cur_valid)
                            begin
                                state_next = S_WRITE;
                            end
                            else
                            begin
                                cmd.blank_start   = 1'b1;
                                cmd.blank_sel_cur = 1'b1;
                                after_write_next  = 1'b1;
                                state_next        = S_BLANK;
                            end
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                    OP_KEY:  state_next = S_KEY;
                    OP_READ: state_next = S_RDREQ;
                    OP_BAR:  state_next = S_BARMUL;
                    default: state_next = S_FINISH;
                endcase
            end
            S_BLANK:
            begin
                cmd.blank_step = 1'b1;
                if (sts.blank_last)
                begin
                    state_next = after_write_reg ? S_WRITE : S_NEWLN;
                end
            end
            S_WRITE:
            begin
                cmd.write_char = 1'b1;
                if (sts.col_wrap)
                begin
                    cmd.blank_start  = 1'b1;
                    after_write_next = 1'b0;
                    state_next       = S_BLANK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_NEWLN:
            begin
                cmd.new_line = 1'b1;
                state_next   = S_FINISH;
            end
            S_KEY:
            begin
                cmd.key_apply = 1'b1;
                state_next    = S_FINISH;
            end
            S_RDREQ:
            begin
                cmd.read_req = 1'b1;
                state_next   = S_RDWAIT;
            end
            S_RDWAIT:
            begin
                cmd.read_cap = 1'b1;
                state_next   = S_FINISH;
            end
            S_BARMUL:
            begin
                cmd.bar_mul = 1'b1;
                state_next  = S_BARCMP;
            end
            S_BARCMP:
            begin
                cmd.bar_cap = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            after_write_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            after_write_reg <= after_write_next;
        end
    end

`ifndef SYNTHESIS
    // An accepted beat always leaves idle
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_DECODE)
        else $error("accepted beat did not start decode");

    // Sweep of a line never ends in finish directly
    a_blank_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BLANK && sts.blank_last |=>
            (state_reg == S_WRITE || state_reg == S_NEWLN))
        else $error("blank sweep exit wrong");

    // Result is only loaded when the output side can take it
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("output loaded while full");
`endif

endmodule

@@ rtl/core/tcs_dp.sv @@
module tcs_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [tcs_pkg::IN_W-1:0]  in_data,
    input  tcs_pkg::dp_cmd_t          cmd,
    output tcs_pkg::dp_sts_t          sts,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [tcs_pkg::OUT_W-1:0] out_data
);
    import tcs_pkg::*;

    localparam int SW = LINE_W + 3;
    localparam int PW = LINE_W + COL_W + 4;

    // Item registers
    op_t         op_reg;
    logic [7:0]  ch_reg;
    logic [8:0]  sc_reg;
    logic [4:0]  row_reg;
    logic [COL_W-1:0] col_reg;

    // Console state
    logic [LINE_W-1:0]  oldest_reg, oldest_next;
    logic [LINE_W-1:0]  next_reg, next_next;
    logic [LINE_W-1:0]  top_reg, top_next;
    logic [LINE_W-1:0]  max_reg, max_next;
    logic               mode_reg, mode_next;
    logic [COL_W-1:0]   column_reg, column_next;
    logic [RING_LINES-1:0] line_valid_reg;

    // Sweep, read and bar registers
    logic [LINE_W-1:0]  blank_line_reg;
    logic [COL_W-1:0]   blank_cnt_reg;
    logic               rd_ok_reg, rd_vld_reg;
    logic [PW-1:0]      xb_reg;
    logic [7:0]         cell_reg;
    logic [OUT_W-1:0]   out_data_reg;
    logic               out_valid_reg;

    // Live position
    logic [LINE_W:0]    span;
    logic [LINE_W-1:0]  live;
    always_comb
    begin
        if (next_reg > oldest_reg)
        begin
            span = {1'b0, next_reg} - {1'b0, oldest_reg};
        end
        else
        begin
            span = {1'b0, next_reg} + (LINE_W+1)'(RING_LINES) - {1'b0, oldest_reg};
        end
        if (span < (LINE_W+1)'(VIEW_ROWS))
        begin
            live = '0;
        end
        else
        begin
            live = LINE_W'(span - (LINE_W+1)'(VIEW_ROWS));
        end
    end

    logic [LINE_W-1:0] first, limit;
    assign limit = mode_reg ? max_reg : live;
    assign first = mode_reg ? top_reg : live;

    // Current line is the newest one
    logic [LINE_W-1:0] cur_line;
    assign cur_line = (next_reg == '0) ? LINE_W'(RING_LINES - 1) : next_reg - 1'b1;

    logic [LINE_W-1:0] next_inc, oldest_inc;
    assign next_inc   = (next_reg == LINE_W'(RING_LINES - 1)) ? '0 : next_reg + 1'b1;
    assign oldest_inc = (oldest_reg == LINE_W'(RING_LINES - 1)) ? '0 : oldest_reg + 1'b1;

    // View line to read
    logic [LINE_W:0]   rel, abs_line;
    logic [LINE_W-1:0] rline;
    logic              rd_ok;
    always_comb
    begin
        rel      = (LINE_W+1)'(first) + (LINE_W+1)'(row_reg);
        abs_line = (LINE_W+1)'(oldest_reg) + rel;
        if (abs_line >= (LINE_W+1)'(RING_LINES))
        begin
            rline = LINE_W'(abs_line - (LINE_W+1)'(RING_LINES));
        end
        else
        begin
            rline = LINE_W'(abs_line);
        end
    end
    assign rd_ok = (row_reg < 5'(VIEW_ROWS)) && (col_reg < COL_W'(LINE_COLS));

    // Ring address and write port
    logic [LINE_W-1:0] a_line;
    logic [COL_W-1:0]  a_col;
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we;
    logic [7:0]        ram_wdata, ram_rdata;
    always_comb
    begin
        if (cmd.blank_step)
        begin
            a_line = blank_line_reg;
            a_col  = blank_cnt_reg;
        end
        else if (cmd.write_char)
        begin
            a_line = cur_line;
            a_col  = column_reg;
        end
        else
        begin
            a_line = rline;
            a_col  = col_reg;
        end
        ram_addr = (ADDR_W'(a_line) << 6) + (ADDR_W'(a_line) << 4) + ADDR_W'(a_col);
    end
    assign ram_we    = cmd.blank_step | cmd.write_char;
    assign ram_wdata = cmd.blank_step ? CH_SPACE : ch_reg;

    tcs_ram #(
        .WIDTH (8),
        .DEPTH (RING_BYTES)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Key moves
    logic              key_hit;
    logic [SW-1:0]     delta, t_new;
    logic [LINE_W-1:0] base_top, base_max;
    always_comb
    begin
        key_hit = 1'b1;
        case (sc_reg)
            SC_UP:        delta = '0 - SW'(1);
            SC_DOWN:      delta = SW'(1);
            SC_PAGE_UP:   delta = '0 - SW'(VIEW_ROWS);
            SC_PAGE_DOWN: delta = SW'(VIEW_ROWS);
            SC_ESC:       delta = SW'(max_reg) - SW'(top_reg) + SW'(1);
            default:
            begin
                delta   = '0;
                key_hit = 1'b0;
            end
        endcase
        base_top = mode_reg ? top_reg : live;
        base_max = mode_reg ? max_reg : live;
        t_new    = SW'(base_top) + delta;
    end

    // State update
    always_comb
    begin
        oldest_next = oldest_reg;
        next_next   = next_reg;
        top_next    = top_reg;
        max_next    = max_reg;
        mode_next   = mode_reg;
        column_next = column_reg;
        if (cmd.write_char)
        begin
            column_next = column_reg + 1'b1;
        end
        if (cmd.new_line)
        begin
            column_next = '0;
            next_next   = next_inc;
            if (next_reg == oldest_reg)
            begin
                oldest_next = oldest_inc;
                if (mode_reg && top_reg != '0)
                begin
                    top_next = top_reg - 1'b1;
                end
            end
            if (mode_reg)
            begin
                if ((LINE_W+1)'(max_reg) + 1'b1 >= (LINE_W+1)'(VIEW_MAX_LIM))
                begin
                    max_next = LINE_W'(VIEW_MAX_LIM);
                end
                else
                begin
                    max_next = max_reg + 1'b1;
                end
            end
        end
        if (cmd.key_apply && key_hit)
        begin
            max_next = base_max;
            if ($signed(t_new) >= $signed(SW'(base_max)))
            begin
                top_next  = base_max;
                mode_next = 1'b0;
            end
            else if ($signed(t_new) < 0)
            begin
                top_next  = '0;
                mode_next = 1'b1;
            end
            else
            begin
                top_next  = LINE_W'(t_new);
                mode_next = 1'b1;
            end
        end
    end

    // Scrollbar compares
    logic [PW-1:0] bar_b, t45, e45, twoxb_b, xb_b;
    logic          left_half, right_half, bar_ok;
    logic [7:0]    glyph;
    always_comb
    begin
        bar_b      = PW'(max_reg) + PW'(VIEW_ROWS);
        t45        = PW'(top_reg) * PW'(BAR_CELLS);
        e45        = (PW'(top_reg) + PW'(VIEW_ROWS)) * PW'(BAR_CELLS);
        twoxb_b    = (xb_reg << 1) + bar_b;
        xb_b       = xb_reg + bar_b;
        left_half  = (xb_reg >= t45) && (twoxb_b < (e45 << 1));
        right_half = (twoxb_b >= (t45 << 1)) && (xb_b < e45);
        if (left_half)
        begin
            glyph = right_half ? GLYPH_BOTH : GLYPH_LEFT;
        end
        else
        begin
            glyph = right_half ? GLYPH_RIGHT : GLYPH_NONE;
        end
        bar_ok = mode_reg && (col_reg < COL_W'(BAR_CELLS));
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg     <= '0;
            next_reg       <= LINE_W'((VIEW_ROWS + 1) % RING_LINES);
            top_reg        <= '0;
            max_reg        <= '0;
            mode_reg       <= 1'b0;
            column_reg     <= '0;
            line_valid_reg <= '0;
            blank_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            oldest_reg <= oldest_next;
            next_reg   <= next_next;
            top_reg    <= top_next;
            max_reg    <= max_next;
            mode_reg   <= mode_next;
            column_reg <= column_next;
            if (cmd.blank_start)
            begin
                blank_cnt_reg <= '0;
            end
            else if (cmd.blank_step)
            begin
                blank_cnt_reg <= blank_cnt_reg + 1'b1;
                if (sts.blank_last)
                begin
                    line_valid_reg[blank_line_reg] <= 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= op_t'(in_data[1:0]);
            ch_reg   <= in_data[9:2];
            sc_reg   <= in_data[18:10];
            row_reg  <= in_data[23:19];
            col_reg  <= in_data[30:24];
            cell_reg <= '0;
        end
        if (cmd.blank_start)
        begin
            blank_line_reg <= cmd.blank_sel_cur ? cur_line : next_reg;
        end
        if (cmd.read_req)
        begin
            rd_ok_reg  <= rd_ok;
            rd_vld_reg <= line_valid_reg[rline];
        end
        if (cmd.read_cap)
        begin
            cell_reg <= !rd_ok_reg ? 8'd0 : (rd_vld_reg ? ram_rdata : CH_SPACE);
        end
        if (cmd.bar_mul)
        begin
            xb_reg <= PW'(col_reg) * bar_b;
        end
        if (cmd.bar_cap)
        begin
            cell_reg <= bar_ok ? glyph : 8'd0;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {7'd0, 8'(limit), 8'(first), mode_reg, ~mode_reg,
                             column_reg, cell_reg};
        end
    end

    // Status
    assign sts.op         = op_reg;
    assign sts.is_newline = (ch_reg == CH_NEWLINE);
    assign sts.is_print   = (ch_reg >= CH_PRINT_LO) && (ch_reg <= CH_PRINT_HI);
    assign sts.cur_valid  = line_valid_reg[cur_line];
    assign sts.blank_last = (blank_cnt_reg == COL_W'(LINE_COLS - 1));
    assign sts.col_wrap   = (column_reg == COL_W'(LINE_COLS - 1));
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // A finished sweep marks its line as holding data
    a_sweep_marks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.blank_step && sts.blank_last |=> line_valid_reg[$past(blank_line_reg)])
        else $error("swept line not marked valid");

    // Cursor never runs past one beyond the last column
    a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
        column_reg <= COL_W'(LINE_COLS))
        else $error("cursor column out of range");

    // Scrolled view never passes the live position
    a_view_order: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg |-> top_reg < max_reg)
        else $error("scrollback view past live position");
`endif

endmodule

@@ rtl/core/text_console_scrollback.sv @@
// Text console with an 80-column line ring and a scrollback view. Each input
// beat is one operation: write a character, apply a key, read a view cell or
// read a scrollbar cell; each gives exactly one result beat carrying the cell
// (0 for writes and keys) and the cursor and view status after the operation.
// A newline sweeps one ring line with spaces through the single RAM port, one
// byte a cycle, and so does a character that fills the last column. The first
// write to a line never used since reset sweeps it as well; no clearing pass
// follows reset. One operation is in flight at a time; the next beat is taken
// in the cycle after the result is loaded, even while that result still waits
// on the output.
module text_console_scrollback (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // opcode[1:0], char_code[9:2], scancode[18:10], row[23:19], col[30:24]
    input  logic [tcs_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // cell_char[7:0], cursor_col[14:8], cursor_visible[15], scrolled_back[16],
    // view_first_line[24:17], view_limit[32:25]
    output logic [tcs_pkg::OUT_W-1:0] m_axis_tdata
);
    import tcs_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    tcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

@@ bench/tb_text_console_scrollback.sv @@
`timescale 1ns / 1ps

module tb_text_console_scrollback;
    import tcs_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // opcode[1:0], char_code[9:2], scancode[18:10], row[23:19], col[30:24]
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // cell_char[7:0], cursor_col[14:8], cursor_visible[15], scrolled_back[16],
    // view_first_line[24:17], view_limit[32:25]
    logic [OUT_W-1:0]     m_axis_tdata;

    typedef struct {
        logic [7:0] char_out;
        logic [6:0] cur_col;
        logic       visible;
        logic       back;
        logic [7:0] first_line;
        logic [7:0] limit_line;
    } console_view_t;

    // Console shadow state
    logic [7:0]    shadow_ring [RING_BYTES];
    int unsigned   oldest_off;
    int unsigned   next_off;
    int            top_line;
    int            max_line;
    bit            in_scroll;
    int unsigned   cur_column;

    console_view_t pending_views[$];
    bit            failed;
    bit            calm;
    bit            hold_req;
    int            hold_cnt;
    int            idle_cycles;

    text_console_scrollback u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned ring_add(int unsigned off, int unsigned n);
        int unsigned r;
        r = off + n;
        while (r >= RING_BYTES) r -= RING_BYTES;
        return r;
    endfunction

    function automatic int live_position();
        int unsigned span;
        int unsigned lines;
        span = (next_off <= oldest_off) ? next_off + RING_BYTES - oldest_off
                                        : next_off - oldest_off;
        lines = span / LINE_COLS;
        return (lines < VIEW_ROWS) ? 0 : int'(lines) - VIEW_ROWS;
    endfunction

    task automatic start_line();
        cur_column = 0;
        for (int i = 0; i < LINE_COLS; i++) shadow_ring[next_off + i] = CH_SPACE;
        if (next_off == oldest_off) begin
            oldest_off = ring_add(oldest_off, LINE_COLS);
            if (in_scroll) begin
                top_line--;
                if (top_line < 0) top_line = 0;
            end
        end
        next_off = ring_add(next_off, LINE_COLS);
        if (in_scroll) begin
            max_line++;
            if (max_line >= VIEW_MAX_LIM) max_line = VIEW_MAX_LIM;
        end
    endtask

    task automatic scroll_by(int lines);
        if (!in_scroll) begin
            top_line  = live_position();
            max_line  = top_line;
            in_scroll = 1'b1;
        end
        top_line += lines;
        if (top_line >= max_line) begin
            top_line  = max_line;
            in_scroll = 1'b0;
        end
        if (top_line < 0) top_line = 0;
    endtask

    function automatic logic [7:0] bar_cell(int unsigned x);
        longint b;
        longint t;
        longint e;
        longint xx;
        bit     left_half;
        bit     right_half;
        b  = longint'(max_line) + VIEW_ROWS;
        t  = top_line;
        e  = t + VIEW_ROWS;
        xx = x;
        left_half  = (xx * b >= t * BAR_CELLS) && ((2 * xx + 1) * b < 2 * BAR_CELLS * e);
        right_half = ((2 * xx + 1) * b >= 2 * BAR_CELLS * t) && ((xx + 1) * b < e * BAR_CELLS);
        if (left_half) return right_half ? GLYPH_BOTH : GLYPH_LEFT;
        return right_half ? GLYPH_RIGHT : GLYPH_NONE;
    endfunction

    // Apply one operation to the shadow console and queue the resulting view
    task automatic predict_view(op_t op, logic [7:0] ch, logic [8:0] sc,
                                logic [4:0] row, logic [6:0] col);
        console_view_t v;
        int            first;
        int            lim;
        int unsigned   cur;
        int unsigned   addr;
        if (op == OP_WRITE) begin
            if (ch == CH_NEWLINE) start_line();
            else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
                cur = ring_add(next_off, RING_BYTES - LINE_COLS);
                if (cur_column >= LINE_COLS) cur_column = 0;
                shadow_ring[cur + cur_column] = ch;
                cur_column++;
                if (cur_column >= LINE_COLS) start_line();
            end
        end else if (op == OP_KEY) begin
            if (sc == SC_UP) scroll_by(-1);
            else if (sc == SC_DOWN) scroll_by(1);
            else if (sc == SC_PAGE_UP) scroll_by(-VIEW_ROWS);
            else if (sc == SC_PAGE_DOWN) scroll_by(VIEW_ROWS);
            else if (sc == SC_ESC) scroll_by(max_line - top_line + 1);
        end
        lim   = in_scroll ? max_line : live_position();
        first = in_scroll ? top_line : lim;
        v.char_out = 8'd0;
        if (op == OP_READ) begin
            if (row < VIEW_ROWS && col < LINE_COLS) begin
                addr = ring_add(oldest_off,
                                ((first + row) % RING_LINES) * LINE_COLS);
                v.char_out = shadow_ring[addr + col];
            end
        end else if (op == OP_BAR) begin
            if (in_scroll && col < BAR_CELLS) v.char_out = bar_cell(col);
        end
        v.cur_col    = cur_column[6:0];
        v.visible    = !in_scroll;
        v.back       = in_scroll;
        v.first_line = first[7:0];
        v.limit_line = lim[7:0];
        pending_views.push_back(v);
    endtask

    // Send one beat; called at a falling edge, returns at a falling edge
    task automatic send_op(op_t op, logic [7:0] ch, logic [8:0] sc,
                           logic [4:0] row, logic [6:0] col);
        while (!calm && $urandom_range(99) < 22) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, col, row, sc, ch, op};
        predict_view(op, ch, sc, row, col);
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    // One random operation; nl_pct sets how often a write is a newline
    task automatic send_random(int nl_pct);
        op_t        op;
        logic [7:0] ch;
        logic [8:0] sc;
        logic [4:0] row;
        logic [6:0] col;
        int         r;
        r  = $urandom_range(99);
        op = (r < 45) ? OP_WRITE : (r < 70) ? OP_KEY : (r < 88) ? OP_READ : OP_BAR;
        ch = 8'($urandom_range(32, 127));
        r  = $urandom_range(99);
        if (r < nl_pct) ch = CH_NEWLINE;
        else if (r >= 88) ch = 8'($urandom_range(255));
        case ($urandom_range(11))
            0, 1:    sc = SC_UP;
            2, 3:    sc = SC_DOWN;
            4, 5:    sc = SC_PAGE_UP;
            6:       sc = SC_PAGE_DOWN;
            7:       sc = SC_ESC;
            8:       sc = SC_PAGE_DOWN;
            default: sc = 9'($urandom_range(511));
        endcase
        row = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(23));
        if ($urandom_range(9) == 0) col = 7'($urandom_range(127));
        else if (op == OP_BAR) col = 7'($urandom_range(44));
        else col = 7'($urandom_range(79));
        send_op(op, ch, sc, row, col);
    endtask

    task automatic test_directed();
        send_op(OP_READ, 8'd0, 9'd0, 5'd0, 7'd0);
        send_op(OP_READ, 8'd0, 9'd0, 5'd31, 7'd127);
        send_op(OP_BAR, 8'd0, 9'd0, 5'd0, 7'd0);
        send_op(OP_WRITE, 8'd65, 9'd0, 5'd0, 7'd0);
        send_op(OP_WRITE, CH_PRINT_LO, 9'd0, 5'd0, 7'd0);
        send_op(OP_WRITE, CH_PRINT_HI, 9'd0, 5'd0, 7'd0);
        send_op(OP_WRITE, 8'd128, 9'd0, 5'd0, 7'd0);
        send_op(OP_WRITE, 8'd0, 9'd0, 5'd0, 7'd0);
        send_op(OP_WRITE, 8'd255, 9'd0, 5'd0, 7'd0);
        send_op(OP_READ, 8'd0, 9'd0, 5'd23, 7'd2);
        send_op(OP_WRITE, CH_NEWLINE, 9'd0, 5'd0, 7'd0);
        send_op(OP_READ, 8'd0, 9'd0, 5'd22, 7'd0);
        send_op(OP_KEY, 8'd0, SC_UP, 5'd0, 7'd0);
        send_op(OP_BAR, 8'd0, 9'd0, 5'd0, 7'd0);
        send_op(OP_KEY, 8'd0, SC_DOWN, 5'd0, 7'd0);
        send_op(OP_KEY, 8'd0, SC_PAGE_UP, 5'd0, 7'd0);
        send_op(OP_BAR, 8'd0, 9'd0, 5'd0, 7'd44);
        send_op(OP_BAR, 8'd0, 9'd0, 5'd0, 7'd45);
        send_op(OP_BAR, 8'd0, 9'd0, 5'd0, 7'd127);
        send_op(OP_READ, 8'd0, 9'd0, 5'd23, 7'd79);
        send_op(OP_KEY, 8'd0, SC_PAGE_DOWN, 5'd0, 7'd0);
        send_op(OP_KEY, 8'd0, SC_UP, 5'd0, 7'd0);
        send_op(OP_KEY, 8'd0, SC_ESC, 5'd0, 7'd0);
        send_op(OP_KEY, 8'd0, 9'h1ff, 5'd0, 7'd0);
    endtask

    // Newline-heavy traffic: more than half of the writes are newlines
    task automatic test_ring_fill();
        for (int i = 0; i < 330; i++) send_random(55);
    endtask

    task automatic test_mixed();
        for (int i = 0; i < 220; i++) send_random(12);
    endtask

    task automatic test_no_idle();
        calm = 1'b1;
        for (int i = 0; i < 100; i++) send_random(20);
        calm = 1'b0;
    endtask

    // Receiver stalls while the sender keeps offering beats
    task automatic test_output_stall();
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) send_random(10);
    endtask

    // Receiver ready
    always @(negedge clk)
    begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = 400;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 22);
        end
    end

    // Result check
    always @(posedge clk)
    begin
        console_view_t v;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_views.size() == 0) begin
                $display("%0t: result beat with nothing pending, got %h", $time,
                         m_axis_tdata);
                failed = 1'b1;
            end else begin
                v = pending_views.pop_front();
                if (m_axis_tdata[7:0] !== v.char_out) begin
                    $display("%0t: cell_char exp %h got %h", $time, v.char_out,
                             m_axis_tdata[7:0]);
                    failed = 1'b1;
                end
                if (m_axis_tdata[14:8] !== v.cur_col) begin
                    $display("%0t: cursor_col exp %0d got %0d", $time, v.cur_col,
                             m_axis_tdata[14:8]);
                    failed = 1'b1;
                end
                if (m_axis_tdata[15] !== v.visible) begin
                    $display("%0t: cursor_visible exp %b got %b", $time, v.visible,
                             m_axis_tdata[15]);
                    failed = 1'b1;
                end
                if (m_axis_tdata[16] !== v.back) begin
                    $display("%0t: scrolled_back exp %b got %b", $time, v.back,
                             m_axis_tdata[16]);
                    failed = 1'b1;
                end
                if (m_axis_tdata[24:17] !== v.first_line) begin
                    $display("%0t: view_first_line exp %0d got %0d", $time,
                             v.first_line, m_axis_tdata[24:17]);
                    failed = 1'b1;
                end
                if (m_axis_tdata[32:25] !== v.limit_line) begin
                    $display("%0t: view_limit exp %0d got %0d", $time,
                             v.limit_line, m_axis_tdata[32:25]);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        failed        = 1'b0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        hold_cnt      = 0;
        idle_cycles   = 0;
        for (int i = 0; i < RING_BYTES; i++) shadow_ring[i] = CH_SPACE;
        oldest_off = 0;
        next_off   = ring_add((VIEW_ROWS + 1) * LINE_COLS, 0);
        top_line   = 0;
        max_line   = 0;
        in_scroll  = 1'b0;
        cur_column = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_ring_fill();
        test_output_stall();
        test_no_idle();
        test_mixed();
        s_axis_tvalid <= 1'b0;

        wait (pending_views.size() == 0);
        repeat (100) @(posedge clk);
        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
